// ----- rtl/tmrlist_pkg.sv -----
package tmrlist_pkg;

	localparam int DEF_MAX_TIMERS = 16;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_SET  = 1'b1;

	typedef enum logic [1:0] {
		KIND_ACCEPTED = 2'd0,
		KIND_REJECTED = 2'd1,
		KIND_FIRED    = 2'd2,
		KIND_DONE     = 2'd3
	} result_kind_t;

	typedef struct packed {
		logic        op;
		logic [63:0] now_time;
		logic [47:0] duration_ns;
		logic        looping;
		logic        action_present;
		logic [7:0]  action_id;
	} tl_in_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [7:0] fired_action;
		logic       last;
	} tl_out_t;

	// one stored timer
	typedef struct packed {
		logic [63:0] start_time;
		logic [47:0] duration;
		logic        looping;
		logic        action_present;
		logic [7:0]  action_id;
	} timer_t;

	// head of the command queue as seen by the back end
	typedef struct packed {
		logic   valid;
		logic   is_set;
		tl_in_t item;
	} q_head_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_PACK
	} back_state_t;

endpackage

// ----- rtl/tmrlist_ram.sv -----
module tmrlist_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/tmrlist_front.sv -----
module tmrlist_front
	import tmrlist_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  tl_in_t  item,
	output q_head_t head,
	input  logic    pop
);

	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	tl_in_t              q_item_q [QUEUE_DEPTH];
	logic                q_set_q  [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   fill_q;
	logic                push;
	logic                do_pop;

	assign busy   = (fill_q == QCNT_W'(QUEUE_DEPTH));
	assign push   = start && !busy;
	assign do_pop = pop && (fill_q != '0);

	assign head.valid  = (fill_q != '0);
	assign head.is_set = q_set_q[rd_ptr_q];
	assign head.item   = q_item_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_item_q[wr_ptr_q] <= item;
			q_set_q[wr_ptr_q]  <= (item.op == OP_SET);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (!push && do_pop) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/tmrlist_back.sv -----
module tmrlist_back
	import tmrlist_pkg::*;
#(
	parameter int MAX_TIMERS = DEF_MAX_TIMERS
) (
	input  logic    clk,
	input  logic    arst_n,
	input  q_head_t head,
	output logic    pop,
	output logic    strobe,
	output tl_out_t result
);

	localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
	localparam int CNT_W = $clog2(MAX_TIMERS + 1);
	localparam int REC_W = $bits(timer_t);

	back_state_t      state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [63:0]      last_tick_q;
	logic [63:0]      now_q;
	logic [IDX_W-1:0] idx_q;
	logic             iss_q;
	logic             valid_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [CNT_W-1:0] kept_q;
	logic [MAX_TIMERS-1:0] rm_q;

	logic             wr_en, rd_en;
	logic [IDX_W-1:0] wr_addr;
	timer_t           wr_data, rd_data;
	logic [REC_W-1:0] rd_raw;

	logic             full;
	logic [63:0]      elapsed;
	logic             fire;
	logic             scan_end;
	logic             pack_end;
	logic             keep;

	logic             res_v;
	tl_out_t          res;

	tmrlist_ram #(
		.WIDTH  (REC_W),
		.DEPTH  (MAX_TIMERS),
		.ADDR_W (IDX_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (idx_q),
		.rd_data (rd_raw)
	);

	assign rd_data  = timer_t'(rd_raw);
	assign full     = (count_q >= CNT_W'(MAX_TIMERS));
	assign elapsed  = now_q - rd_data.start_time;
	assign fire     = (elapsed >= {16'd0, rd_data.duration});
	assign scan_end = valid_s1 && (idx_s1 == '0);
	assign pack_end = valid_s1 && (CNT_W'(idx_s1) == count_q - CNT_W'(1));
	assign keep     = !rm_q[idx_s1];

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (head.valid && !head.is_set && count_q != '0) begin
					state_d = BK_SCAN;
				end
			end
			BK_SCAN: begin
				if (scan_end) begin
					state_d = BK_PACK;
				end
			end
			BK_PACK: begin
				if (pack_end) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop     = 1'b0;
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_data = rd_data;
		rd_en   = 1'b0;
		res_v   = 1'b0;
		res     = '0;
		case (state_q)
			BK_IDLE: begin
				if (head.valid) begin
					pop   = 1'b1;
					res_v = 1'b1;
					res.last = 1'b1;
					if (head.is_set) begin
						if (full) begin
							res.result_kind = KIND_REJECTED;
						end else begin
							res.result_kind        = KIND_ACCEPTED;
							wr_en                  = 1'b1;
							wr_addr                = IDX_W'(count_q);
							wr_data.start_time     = last_tick_q;
							wr_data.duration       = head.item.duration_ns;
							wr_data.looping        = head.item.looping;
							wr_data.action_present = head.item.action_present;
							wr_data.action_id      = head.item.action_id;
						end
					end else if (count_q == '0) begin
						res.result_kind = KIND_DONE;
					end else begin
						res_v = 1'b0;
					end
				end
			end
			BK_SCAN: begin
				rd_en = iss_q;
				if (valid_s1 && fire) begin
					if (rd_data.action_present) begin
						res_v            = 1'b1;
						res.result_kind  = KIND_FIRED;
						res.fired_action = rd_data.action_id;
					end
					if (rd_data.looping) begin
						wr_en              = 1'b1;
						wr_data.start_time = now_q;
					end
				end
			end
			BK_PACK: begin
				rd_en = iss_q;
				// survivors slide down to the next free slot
				if (valid_s1 && keep) begin
					wr_en   = 1'b1;
					wr_addr = IDX_W'(kept_q);
				end
				if (pack_end) begin
					res_v           = 1'b1;
					res.result_kind = KIND_DONE;
					res.last        = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			count_q     <= '0;
			last_tick_q <= '0;
			iss_q       <= 1'b0;
			valid_s1    <= 1'b0;
			strobe      <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= rd_en;
			strobe   <= res_v;
			case (state_q)
				BK_IDLE: begin
					if (head.valid) begin
						if (head.is_set) begin
							if (!full) begin
								count_q <= count_q + CNT_W'(1);
							end
						end else begin
							last_tick_q <= head.item.now_time;
							iss_q       <= (count_q != '0);
						end
					end
				end
				BK_SCAN: begin
					if (iss_q && idx_q == '0) begin
						iss_q <= 1'b0;
					end
					if (scan_end) begin
						iss_q <= 1'b1;
					end
				end
				BK_PACK: begin
					if (iss_q && CNT_W'(idx_q) == count_q - CNT_W'(1)) begin
						iss_q <= 1'b0;
					end
					if (pack_end) begin
						count_q <= kept_q + CNT_W'(keep);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		result <= res;
		case (state_q)
			BK_IDLE: begin
				if (head.valid && !head.is_set) begin
					now_q <= head.item.now_time;
					rm_q  <= '0;
					idx_q <= IDX_W'(count_q - CNT_W'(1));
				end
			end
			BK_SCAN: begin
				if (iss_q && idx_q != '0) begin
					idx_q <= idx_q - IDX_W'(1);
				end
				if (valid_s1 && fire && !rd_data.looping) begin
					rm_q[idx_s1] <= 1'b1;
				end
				if (scan_end) begin
					idx_q  <= '0;
					kept_q <= '0;
				end
			end
			BK_PACK: begin
				if (iss_q && CNT_W'(idx_q) != count_q - CNT_W'(1)) begin
					idx_q <= idx_q + IDX_W'(1);
				end
				if (valid_s1 && keep) begin
					kept_q <= kept_q + CNT_W'(1);
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- rtl/periodic_and_one_shot_timer_list_top.sv -----
// channel   dir  handshake                 payload
// command   in   start high, busy low      item   (tl_in_t)
// result    out  strobe, one cycle, no hold result (tl_out_t)
//
// a set is handled by the executor straight from its idle state; a tick with timers
// held walks the timer memory twice (an empty list gives its done result without a walk):
// a fire pass from newest to oldest and a compaction pass from oldest to newest
// reset clears the timer count and the last tick time; the memory is not cleared
// a two-entry command queue takes new commands while the executor runs
// results cannot be stalled and leave through an output register
module periodic_and_one_shot_timer_list_top
	import tmrlist_pkg::*;
#(
	parameter int MAX_TIMERS = DEF_MAX_TIMERS
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  tl_in_t  item,
	output logic    strobe,
	output tl_out_t result
);

	q_head_t head;
	logic    pop;

	tmrlist_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.head   (head),
		.pop    (pop)
	);

	tmrlist_back #(
		.MAX_TIMERS (MAX_TIMERS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.strobe (strobe),
		.result (result)
	);

endmodule

// ----- rtl/tmrlist_chk.sv -----
module tmrlist_chk
	import tmrlist_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    strobe,
	input tl_out_t result
);

	// only fired results leave a tick transaction open
	a_open_is_fired: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |-> result.result_kind == KIND_FIRED)
		else $error("non-final result is not a fired result");

	a_fired_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.result_kind == KIND_FIRED |-> !result.last)
		else $error("fired result marked last");

	a_action_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.result_kind != KIND_FIRED |-> result.fired_action == 8'd0)
		else $error("action id on a result that is not fired");

	// the queue only fills after taking a transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without an accepted transaction");

endmodule

bind periodic_and_one_shot_timer_list_top tmrlist_chk u_chk (.*);
